FILE: sv/cbc_pkg.sv
package cbc_pkg;

    localparam int ADDR_W      = 16;
    localparam int DATA_W      = 8;
    localparam int ROM_BANK_W  = 7;
    localparam int EXT_BANK_W  = 4;
    localparam int RTC_IDX_W   = 4;
    localparam int CTYPE_W     = 2;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam int RTC_COUNT   = 5;
    localparam int RTC_SEL_W   = $clog2(RTC_COUNT);

    localparam logic [CTYPE_W-1:0] CTYPE_MBC1 = 2'd0;
    localparam logic [CTYPE_W-1:0] CTYPE_MBC2 = 2'd1;
    localparam logic [CTYPE_W-1:0] CTYPE_MBC3 = 2'd2;

    // Register index taken from paddr[2].
    localparam logic REG_CTYPE = 1'b0;

    localparam logic [DATA_W-1:0] RAM_EN_KEY = 8'h0A;
    localparam logic [DATA_W-1:0] RAM_DIS_KEY = 8'h00;

    // Address window of a control write, from address bits 14:13.
    typedef enum logic [1:0] {
        REGION_RAM_EN  = 2'd0,
        REGION_ROM_LO  = 2'd1,
        REGION_UPPER   = 2'd2,
        REGION_MODE    = 2'd3
    } region_t;

    typedef struct packed {
        logic                  func;
        logic [ADDR_W-1:0]     address;
        logic [DATA_W-1:0]     data;
        logic [RTC_IDX_W-1:0]  rtc_index;
    } wr_item_t;

    typedef struct packed {
        logic [ROM_BANK_W-1:0] rom_bank;
        logic [EXT_BANK_W-1:0] ext_bank;
        logic                  ext_en;
        logic                  map_mode;
        logic [DATA_W-1:0]     rtc_value;
    } bank_view_t;

    // Bank numbers whose low five bits are zero step to the next bank.
    function automatic logic [ROM_BANK_W-1:0] remap_mbc1(input logic [ROM_BANK_W-1:0] b);
        logic [ROM_BANK_W-1:0] r;
        r = b;
        if (b[4:0] == 5'd0)
        begin
            r = b | 7'd1;
        end
        return r;
    endfunction

    // True for clock register numbers 8 through 12.
    function automatic logic is_rtc_sel(input logic [EXT_BANK_W-1:0] v);
        return v[3] && (v[2:0] <= 3'd4);
    endfunction

endpackage

FILE: sv/cbc_apb_regs.sv
module cbc_apb_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [cbc_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [cbc_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [cbc_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready,
    output logic [cbc_pkg::CTYPE_W-1:0]        ctype
);

    logic [cbc_pkg::CTYPE_W-1:0] ctype_reg;
    logic [cbc_pkg::CTYPE_W-1:0] ctype_next;
    logic                        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb
    begin
        ctype_next = ctype_reg;
        if (wr_en && (paddr[2] == cbc_pkg::REG_CTYPE))
        begin
            ctype_next = pwdata[cbc_pkg::CTYPE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctype_reg <= cbc_pkg::CTYPE_MBC1;
        end
        else
        begin
            ctype_reg <= ctype_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == cbc_pkg::REG_CTYPE)
        begin
            prdata = {{(cbc_pkg::APB_DATA_W-cbc_pkg::CTYPE_W){1'b0}}, ctype_reg};
        end
    end

    assign ctype = ctype_reg;

endmodule

FILE: sv/cbc_bank_state.sv
module cbc_bank_state (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [cbc_pkg::CTYPE_W-1:0]   ctype,
    input  logic                          upd,
    input  cbc_pkg::wr_item_t             item,
    output cbc_pkg::bank_view_t           view_next
);

    logic [cbc_pkg::ROM_BANK_W-1:0] rom_bank_reg, rom_bank_next;
    logic [cbc_pkg::EXT_BANK_W-1:0] ext_bank_reg, ext_bank_next;
    logic                           ram_en_reg, ram_en_next;
    logic                           mode_reg, mode_next;
    logic [cbc_pkg::DATA_W-1:0]     clock_reg [cbc_pkg::RTC_COUNT];
    logic                           clk_wr;
    logic [cbc_pkg::RTC_SEL_W-1:0]  clk_wsel;
    logic [cbc_pkg::RTC_SEL_W-1:0]  clk_rsel;
    logic                           is2, is3;
    logic                           mbc3_ram_ok;
    cbc_pkg::region_t               region;

    assign is2    = (ctype == cbc_pkg::CTYPE_MBC2);
    assign is3    = (ctype == cbc_pkg::CTYPE_MBC3);
    assign region = cbc_pkg::region_t'(item.address[14:13]);
    assign mbc3_ram_ok = (item.data[7:4] == 4'd0) &&
                         ((item.data[3:2] == 2'd0) || cbc_pkg::is_rtc_sel(item.data[3:0]));

    assign clk_wr   = upd && item.func && cbc_pkg::is_rtc_sel(item.rtc_index);
    assign clk_wsel = item.rtc_index[cbc_pkg::RTC_SEL_W-1:0];

    always_comb
    begin
        rom_bank_next = rom_bank_reg;
        ext_bank_next = ext_bank_reg;
        ram_en_next   = ram_en_reg;
        mode_next     = mode_reg;
        if (upd && !item.func && !item.address[15])
        begin
            case (region)
                cbc_pkg::REGION_RAM_EN:
                begin
                    if (is3)
                    begin
                        if (item.data == cbc_pkg::RAM_EN_KEY)
                        begin
                            ram_en_next = 1'b1;
                        end
                        else if (item.data == cbc_pkg::RAM_DIS_KEY)
                        begin
                            ram_en_next = 1'b0;
                        end
                    end
                    else if (!(is2 && item.address[8]))
                    begin
                        ram_en_next = (item.data[3:0] == cbc_pkg::RAM_EN_KEY[3:0]);
                    end
                end
                cbc_pkg::REGION_ROM_LO:
                begin
                    if (is2)
                    begin
                        if (item.address[8])
                        begin
                            rom_bank_next = (item.data[3:0] == 4'd0) ? 7'd1 :
                                            {3'd0, item.data[3:0]};
                        end
                    end
                    else if (is3)
                    begin
                        rom_bank_next = (item.data[6:0] == 7'd0) ? 7'd1 : item.data[6:0];
                    end
                    else
                    begin
                        rom_bank_next = cbc_pkg::remap_mbc1({rom_bank_reg[6:5],
                                                             item.data[4:0]});
                    end
                end
                cbc_pkg::REGION_UPPER:
                begin
                    if (is3)
                    begin
                        if (mbc3_ram_ok)
                        begin
                            ext_bank_next = item.data[3:0];
                        end
                    end
                    else if (!is2)
                    begin
                        if (!mode_reg)
                        begin
                            rom_bank_next = cbc_pkg::remap_mbc1({item.data[6:5],
                                                                 rom_bank_reg[4:0]});
                        end
                        else if (item.data[7:2] == 6'd0)
                        begin
                            ext_bank_next = item.data[3:0];
                        end
                    end
                end
                cbc_pkg::REGION_MODE:
                begin
                    if (!is2)
                    begin
                        mode_next = item.data[0];
                        if (item.data[0])
                        begin
                            // RAM banking drops the upper ROM bits, no bank-zero step.
                            rom_bank_next = {2'd0, rom_bank_reg[4:0]};
                        end
                        else
                        begin
                            ext_bank_next = '0;
                        end
                    end
                end
                default:
                begin
                    rom_bank_next = rom_bank_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_bank_reg <= 7'd1;
            ext_bank_reg <= '0;
            ram_en_reg   <= 1'b0;
            mode_reg     <= 1'b0;
            for (int i = 0; i < cbc_pkg::RTC_COUNT; i++)
            begin
                clock_reg[i] <= '0;
            end
        end
        else
        begin
            rom_bank_reg <= rom_bank_next;
            ext_bank_reg <= ext_bank_next;
            ram_en_reg   <= ram_en_next;
            mode_reg     <= mode_next;
            if (clk_wr)
            begin
                clock_reg[clk_wsel] <= item.data;
            end
        end
    end

    // The reported clock value must already include a write by the same beat.
    assign clk_rsel = ext_bank_next[cbc_pkg::RTC_SEL_W-1:0];

    always_comb
    begin
        view_next.rom_bank  = rom_bank_next;
        view_next.ext_bank  = ext_bank_next;
        view_next.ext_en    = ram_en_next;
        view_next.map_mode  = mode_next;
        view_next.rtc_value = '0;
        if (cbc_pkg::is_rtc_sel(ext_bank_next))
        begin
            if (clk_wr && (clk_wsel == clk_rsel))
            begin
                view_next.rtc_value = item.data;
            end
            else
            begin
                view_next.rtc_value = clock_reg[clk_rsel];
            end
        end
    end

endmodule

FILE: sv/cartridge_bank_controller_unit.sv
// An accepted beat is held in the input register; its result then goes to the result register,
// which drives the outputs. Throughput: one beat per cycle unless out_stall holds back a waiting result.
// The input register and the result register are each one beat deep.
// Reset (rst_n, asynchronous, active low): ROM bank 1, RAM bank 0, RAM disabled,
// ROM banking mode, clock registers zero, controller type MBC1, pipeline empty.
module cartridge_bank_controller_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               func,
    input  logic [cbc_pkg::ADDR_W-1:0]         address,
    input  logic [cbc_pkg::DATA_W-1:0]         data,
    input  logic [cbc_pkg::RTC_IDX_W-1:0]      rtc_index,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [cbc_pkg::ROM_BANK_W-1:0]     rom_bank,
    output logic [cbc_pkg::EXT_BANK_W-1:0]     ext_bank,
    output logic                               ext_en,
    output logic                               map_mode,
    output logic [cbc_pkg::DATA_W-1:0]         rtc_value,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [cbc_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [cbc_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [cbc_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);

    logic                        in_valid_reg;
    cbc_pkg::wr_item_t           item_reg;
    logic                        out_valid_reg;
    cbc_pkg::bank_view_t         view_reg;
    cbc_pkg::bank_view_t         view_next;
    cbc_pkg::wr_item_t           item_in;
    logic [cbc_pkg::CTYPE_W-1:0] ctype;
    logic                        adv;
    logic                        upd;

    cbc_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .ctype   (ctype)
    );

    // The result stage moves whenever it is empty or its beat is being taken.
    assign adv      = !out_valid_reg || !out_stall;
    assign upd      = in_valid_reg && adv;
    assign in_stall = in_valid_reg && !adv;

    assign item_in.func      = func;
    assign item_in.address   = address;
    assign item_in.data      = data;
    assign item_in.rtc_index = rtc_index;

    cbc_bank_state u_state (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctype     (ctype),
        .upd       (upd),
        .item      (item_reg),
        .view_next (view_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            if (adv)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            item_reg <= item_in;
        end
        if (upd)
        begin
            view_reg <= view_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign rom_bank  = view_reg.rom_bank;
    assign ext_bank  = view_reg.ext_bank;
    assign ext_en    = view_reg.ext_en;
    assign map_mode  = view_reg.map_mode;
    assign rtc_value = view_reg.rtc_value;

`ifndef SYNTHESIS
    a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> !in_stall)
        else $error("input stalled while the result stage is empty");

    a_ext_bank_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((view_reg.ext_bank[3:2] == 2'd0) ||
                           (view_reg.ext_bank[3] && (view_reg.ext_bank[2:0] <= 3'd4))))
        else $error("reported RAM bank outside the legal set");

    a_rtc_needs_clock_sel: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (view_reg.rtc_value != '0)) |-> view_reg.ext_bank[3])
        else $error("clock value reported without a clock register selected");
`endif

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam logic FUNC_CTRL = 1'b0;
    localparam logic FUNC_CLOCK = 1'b1;
    localparam logic [cbc_pkg::RTC_IDX_W-1:0] RTC_FIRST = 4'd8;
    localparam logic [cbc_pkg::RTC_IDX_W-1:0] RTC_LAST = 4'd12;
    localparam logic [cbc_pkg::APB_ADDR_W-1:0] CTYPE_ADDR = 3'd0;
    // Type three is not defined and decodes like MBC1.
    localparam logic [cbc_pkg::CTYPE_W-1:0] CTYPE_ALIAS = 2'd3;
    localparam int CYCLE_LIMIT = 200000;
    localparam int REPORT_MAX = 10;

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic func;
    logic [cbc_pkg::ADDR_W-1:0] address;
    logic [cbc_pkg::DATA_W-1:0] data;
    logic [cbc_pkg::RTC_IDX_W-1:0] rtc_index;
    logic out_valid;
    logic out_stall;
    logic [cbc_pkg::ROM_BANK_W-1:0] rom_bank;
    logic [cbc_pkg::EXT_BANK_W-1:0] ext_bank;
    logic ext_en;
    logic map_mode;
    logic [cbc_pkg::DATA_W-1:0] rtc_value;
    logic psel;
    logic penable;
    logic pwrite;
    logic [cbc_pkg::APB_ADDR_W-1:0] paddr;
    logic [cbc_pkg::APB_DATA_W-1:0] pwdata;
    logic [cbc_pkg::APB_DATA_W-1:0] prdata;
    logic pready;

    cartridge_bank_controller_unit uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .func(func),
        .address(address),
        .data(data),
        .rtc_index(rtc_index),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .rom_bank(rom_bank),
        .ext_bank(ext_bank),
        .ext_en(ext_en),
        .map_mode(map_mode),
        .rtc_value(rtc_value),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always #2 clk = ~clk;

    // Mapper state as the CPU would see it.
    logic [cbc_pkg::CTYPE_W-1:0] ctype_model;
    logic [cbc_pkg::ROM_BANK_W-1:0] rom_sel;
    logic [cbc_pkg::EXT_BANK_W-1:0] ram_sel;
    logic ram_on;
    logic mode_sel;
    logic [cbc_pkg::DATA_W-1:0] clock_bytes [cbc_pkg::RTC_COUNT];

    cbc_pkg::wr_item_t cpu_writes [$];
    cbc_pkg::bank_view_t expected_views [$];
    cbc_pkg::wr_item_t cur_write;
    cbc_pkg::bank_view_t want;
    cbc_pkg::bank_view_t got;
    bit holding;
    bit beat_taken;
    bit idle_on;
    int send_gap;
    int stall_left;
    int fault_count;
    int results_seen;
    int clock_writes;
    int rtc_views;
    int ctype_writes;
    int cycle_count;

    // MBC1 cannot reach banks 0x00, 0x20, 0x40 and 0x60; it lands one bank higher.
    function automatic logic [cbc_pkg::ROM_BANK_W-1:0] skip_bank_zero(
        input logic [cbc_pkg::ROM_BANK_W-1:0] b);
        if (b[4:0] == 5'd0)
        begin
            return b + 7'd1;
        end
        return b;
    endfunction

    function automatic cbc_pkg::bank_view_t apply_cpu_write(input cbc_pkg::wr_item_t w);
        cbc_pkg::bank_view_t v;
        logic mbc2;
        logic mbc3;
        mbc2 = (ctype_model == cbc_pkg::CTYPE_MBC2);
        mbc3 = (ctype_model == cbc_pkg::CTYPE_MBC3);
        if (w.func == FUNC_CLOCK)
        begin
            if (w.rtc_index >= RTC_FIRST && w.rtc_index <= RTC_LAST)
            begin
                clock_bytes[w.rtc_index - RTC_FIRST] = w.data;
            end
        end
        else if (w.address <= 16'h1FFF)
        begin
            // MBC2 only decodes RAM enable with address bit 8 clear.
            if (!(mbc2 && w.address[8]))
            begin
                if (mbc3)
                begin
                    if (w.data == cbc_pkg::RAM_EN_KEY)
                    begin
                        ram_on = 1'b1;
                    end
                    else if (w.data == cbc_pkg::RAM_DIS_KEY)
                    begin
                        ram_on = 1'b0;
                    end
                end
                else
                begin
                    ram_on = (w.data[3:0] == 4'hA);
                end
            end
        end
        else if (w.address <= 16'h3FFF)
        begin
            if (mbc2)
            begin
                if (w.address[8])
                begin
                    rom_sel = (w.data[3:0] == 4'd0) ? 7'd1 : {3'd0, w.data[3:0]};
                end
            end
            else if (mbc3)
            begin
                rom_sel = (w.data[6:0] == 7'd0) ? 7'd1 : w.data[6:0];
            end
            else
            begin
                rom_sel = skip_bank_zero({rom_sel[6:5], w.data[4:0]});
            end
        end
        else if (w.address <= 16'h5FFF)
        begin
            if (mbc3)
            begin
                if (w.data <= 8'd3 || (w.data >= 8'd8 && w.data <= 8'd12))
                begin
                    ram_sel = w.data[3:0];
                end
            end
            else if (!mbc2)
            begin
                if (!mode_sel)
                begin
                    rom_sel = skip_bank_zero({w.data[6:5], rom_sel[4:0]});
                end
                else if (w.data <= 8'd3)
                begin
                    ram_sel = w.data[3:0];
                end
            end
        end
        else if (w.address <= 16'h7FFF)
        begin
            if (!mbc2)
            begin
                mode_sel = w.data[0];
                if (mode_sel)
                begin
                    rom_sel[6:5] = 2'b00;
                end
                else
                begin
                    ram_sel = 4'd0;
                end
            end
        end
        v.rom_bank = rom_sel;
        v.ext_bank = ram_sel;
        v.ext_en = ram_on;
        v.map_mode = mode_sel;
        v.rtc_value = (ram_sel >= RTC_FIRST && ram_sel <= RTC_LAST) ?
                      clock_bytes[ram_sel - RTC_FIRST] : 8'h00;
        return v;
    endfunction

    // Input driver: a beat stays on the bus until it is taken.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (beat_taken)
            begin
                beat_taken = 1'b0;
                holding = 1'b0;
                if (idle_on && $urandom_range(0, 7) == 0)
                begin
                    send_gap = $urandom_range(1, 16);
                end
            end
            if (!holding)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                end
                else if (cpu_writes.size() != 0)
                begin
                    cur_write = cpu_writes.pop_front();
                    holding = 1'b1;
                end
            end
            in_valid <= holding;
            func <= cur_write.func;
            address <= cur_write.address;
            data <= cur_write.data;
            rtc_index <= cur_write.rtc_index;

            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(0, 15);
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // Monitor: predict on each accepted input beat, check each accepted result beat.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                expected_views.push_back(apply_cpu_write(cur_write));
                if (cur_write.func == FUNC_CLOCK)
                begin
                    clock_writes++;
                end
                beat_taken = 1'b1;
            end
            if (out_valid && !out_stall)
            begin
                results_seen++;
                got.rom_bank = rom_bank;
                got.ext_bank = ext_bank;
                got.ext_en = ext_en;
                got.map_mode = map_mode;
                got.rtc_value = rtc_value;
                if (expected_views.size() == 0)
                begin
                    fault_count++;
                    if (fault_count <= REPORT_MAX)
                    begin
                        $display("result %0d arrived with nothing expected", results_seen);
                    end
                end
                else
                begin
                    want = expected_views.pop_front();
                    if (want.ext_bank >= RTC_FIRST)
                    begin
                        rtc_views++;
                    end
                    if (got.rom_bank !== want.rom_bank || got.ext_bank !== want.ext_bank ||
                        got.ext_en !== want.ext_en ||
                        got.map_mode !== want.map_mode || got.rtc_value !== want.rtc_value)
                    begin
                        fault_count++;
                        if (fault_count <= REPORT_MAX)
                        begin
                            $display({"result %0d (exp/got): rom %h/%h ram %h/%h",
                                      " en %b/%b mode %b/%b rtc %h/%h"},
                                     results_seen, want.rom_bank, got.rom_bank,
                                     want.ext_bank, got.ext_bank, want.ext_en,
                                     got.ext_en, want.map_mode, got.map_mode,
                                     want.rtc_value, got.rtc_value);
                        end
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count,
                     expected_views.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic queue_write(input logic f, input logic [cbc_pkg::ADDR_W-1:0] a,
                               input logic [cbc_pkg::DATA_W-1:0] d,
                               input logic [cbc_pkg::RTC_IDX_W-1:0] i);
        cbc_pkg::wr_item_t w;
        w.func = f;
        w.address = a;
        w.data = d;
        w.rtc_index = i;
        cpu_writes.push_back(w);
    endtask

    task automatic queue_random(input int n);
        cbc_pkg::wr_item_t w;
        for (int k = 0; k < n; k++)
        begin
            w.func = ($urandom_range(0, 3) == 0) ? FUNC_CLOCK : FUNC_CTRL;
            w.rtc_index = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) :
                          4'($urandom_range(8, 12));
            if ($urandom_range(0, 9) == 0)
            begin
                w.address = 16'($urandom_range(16'h8000, 16'hFFFF));
            end
            else
            begin
                w.address = {1'b0, 2'($urandom_range(0, 3)), 13'($urandom)};
            end
            case ($urandom_range(0, 4))
                0: w.data = 8'($urandom_range(0, 3));
                1: w.data = 8'($urandom_range(8, 12));
                2: w.data = ($urandom_range(0, 1) != 0) ? cbc_pkg::RAM_EN_KEY :
                            cbc_pkg::RAM_DIS_KEY;
                3: w.data = {1'b0, 2'($urandom_range(0, 3)), 5'd0};
                default: w.data = 8'($urandom);
            endcase
            cpu_writes.push_back(w);
        end
    endtask

    task automatic wait_idle();
        while (cpu_writes.size() != 0 || holding || expected_views.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    // Register write, then a read back of the same register.
    task automatic set_controller(input logic [cbc_pkg::CTYPE_W-1:0] kind);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= CTYPE_ADDR;
        pwdata <= cbc_pkg::APB_DATA_W'(kind);
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (pready !== 1'b1 || prdata !== cbc_pkg::APB_DATA_W'(kind))
        begin
            fault_count++;
            if (fault_count <= REPORT_MAX)
            begin
                $display("controller type read back %h (ready %b), wrote %h",
                         prdata, pready, kind);
            end
        end
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        ctype_model = kind;
        ctype_writes++;
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        func = FUNC_CTRL;
        address = '0;
        data = '0;
        rtc_index = '0;
        out_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cur_write = '0;
        ctype_model = cbc_pkg::CTYPE_MBC1;
        rom_sel = 7'd1;
        ram_sel = 4'd0;
        ram_on = 1'b0;
        mode_sel = 1'b0;
        for (int k = 0; k < cbc_pkg::RTC_COUNT; k++)
        begin
            clock_bytes[k] = 8'h00;
        end
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        idle_on = 1'b1;

        set_controller(cbc_pkg::CTYPE_MBC1);
        queue_write(FUNC_CTRL, 16'h0000, 8'h0A, 4'd0);
        queue_write(FUNC_CTRL, 16'h2000, 8'h00, 4'd15);
        queue_write(FUNC_CTRL, 16'h3FFF, 8'hFF, 4'd0);
        queue_write(FUNC_CTRL, 16'h4000, 8'h63, 4'd0);
        queue_write(FUNC_CTRL, 16'h2000, 8'h20, 4'd0);
        queue_write(FUNC_CTRL, 16'h6000, 8'h01, 4'd0);
        queue_write(FUNC_CTRL, 16'h4000, 8'h07, 4'd0);
        queue_write(FUNC_CTRL, 16'h5FFF, 8'h03, 4'd0);
        queue_write(FUNC_CTRL, 16'hFFFF, 8'hFF, 4'd0);
        queue_write(FUNC_CLOCK, 16'hFFFF, 8'hFF, 4'd8);
        queue_write(FUNC_CLOCK, 16'h0000, 8'h55, 4'd15);
        queue_write(FUNC_CTRL, 16'h7FFF, 8'hFE, 4'd0);
        queue_write(FUNC_CTRL, 16'h1FFF, 8'h1A, 4'd0);
        queue_write(FUNC_CTRL, 16'h00FF, 8'hF0, 4'd0);
        queue_random(250);
        wait_idle();

        set_controller(cbc_pkg::CTYPE_MBC2);
        queue_write(FUNC_CTRL, 16'h0000, 8'h0A, 4'd0);
        queue_write(FUNC_CTRL, 16'h0100, 8'h00, 4'd0);
        queue_write(FUNC_CTRL, 16'h2100, 8'h00, 4'd0);
        queue_write(FUNC_CTRL, 16'h3FFF, 8'hFF, 4'd0);
        queue_write(FUNC_CTRL, 16'h2000, 8'h05, 4'd0);
        queue_write(FUNC_CTRL, 16'h4000, 8'h02, 4'd0);
        queue_write(FUNC_CTRL, 16'h6000, 8'h01, 4'd0);
        queue_random(200);
        wait_idle();

        set_controller(cbc_pkg::CTYPE_MBC3);
        queue_write(FUNC_CTRL, 16'h0000, 8'h05, 4'd0);
        queue_write(FUNC_CTRL, 16'h2000, 8'h00, 4'd0);
        queue_write(FUNC_CTRL, 16'h2000, 8'hFF, 4'd0);
        queue_write(FUNC_CLOCK, 16'h0000, 8'hA5, 4'd12);
        queue_write(FUNC_CTRL, 16'h4000, 8'h0C, 4'd0);
        queue_write(FUNC_CTRL, 16'h4000, 8'h0D, 4'd0);
        queue_write(FUNC_CTRL, 16'h5000, 8'h04, 4'd0);
        queue_write(FUNC_CTRL, 16'h6000, 8'h01, 4'd0);
        queue_random(300);
        wait_idle();

        set_controller(CTYPE_ALIAS);
        queue_random(200);
        wait_idle();

        // Closing stretch runs at full rate on both sides.
        idle_on = 1'b0;
        set_controller(cbc_pkg::CTYPE_MBC3);
        queue_random(250);
        wait_idle();
        repeat (8) @(posedge clk);
        if (expected_views.size() != 0)
        begin
            fault_count++;
            $display("%0d results never arrived", expected_views.size());
        end

        $display("%0d CPU writes checked (%0d clock writes, %0d with a clock register on)",
                 results_seen, clock_writes, rtc_views);
        $display("controller type written %0d times across all four codes", ctype_writes);
        if (fault_count == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
